// ===== rtl/bbwc_pkg.sv =====
// Package for the bar width classifier: field widths, defaults, pattern tables.
// No dependencies; used by bbwc_classify and barcode_bar_width_classifier_top.
package bbwc_pkg;

    // Parameter defaults
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF   = 32;

    // Symbol geometry
    localparam int NUM_BARS  = 5;
    localparam int NUM_GAPS  = 4;
    localparam int SLOT_BITS = $clog2(NUM_BARS);
    localparam int GAP_IDX_BITS = $clog2(NUM_GAPS);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_BARS - 1);

    // Configuration register
    localparam int CFG_BITS = 12;
    localparam logic [CFG_BITS-1:0] DARK_THR_RST = 12'd2048;

    // Result field widths
    localparam int IDX_BITS   = 6;
    localparam int CODE_BITS  = 4;

    // Wide bar pairs, tried in this order; pair k gives code k+1
    localparam int NUM_PAIRS = 10;
    localparam logic [SLOT_BITS-1:0] PAIR_A [NUM_PAIRS] =
        '{3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd3, 3'd0, 3'd1, 3'd2};
    localparam logic [SLOT_BITS-1:0] PAIR_B [NUM_PAIRS] =
        '{3'd4, 3'd4, 3'd1, 3'd4, 3'd2, 3'd2, 3'd4, 3'd3, 3'd3, 3'd3};
    localparam logic [CODE_BITS-1:0] CODE_NONE = 4'd0;

    // Wide gap offsets, gap 1 first, gap 0 last
    localparam logic [IDX_BITS-1:0] GAP1_OFS = 6'd0;
    localparam logic [IDX_BITS-1:0] GAP2_OFS = 6'd9;
    localparam logic [IDX_BITS-1:0] GAP3_OFS = 6'd19;
    localparam logic [IDX_BITS-1:0] GAP0_OFS = 6'd29;
    localparam logic [IDX_BITS-1:0] GAP_NONE_OFS = 6'd0;

    // One decoded symbol
    typedef struct packed {
        logic [IDX_BITS-1:0] pattern_index;
        logic [NUM_BARS-1:0] wide_bar_mask;
        logic [NUM_GAPS-1:0] wide_gap_mask;
    } t_result;

endpackage

// ===== rtl/barcode_bar_width_classifier_top.sv =====
// Bar width classifier top: thresholding, bar timing store, width and result stages.
// Depends on bbwc_pkg and bbwc_classify.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_sample, i_elapsed_time
//  output   | o_out_valid  | i_out_stall  | o_pattern_index, o_wide_bar_mask,
//           |              |              | o_wide_gap_mask
//  config   | i_cfg_wr_en  | -            | i_cfg_wr_data
//
// One sample is taken every cycle while o_in_stall is low. The fifth bar end yields a
// result through the width subtractors into the width register, then through the
// comparator network into the result register. Reset loads the default threshold
// and clears the bar state and both stage valids. Input stalls only when both
// stages hold a symbol and the output is stalled.
module barcode_bar_width_classifier_top #(
    parameter int SAMPLE_BITS = bbwc_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = bbwc_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bbwc_pkg::CFG_BITS-1:0]   i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic [TIME_BITS-1:0]            i_elapsed_time,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bbwc_pkg::IDX_BITS-1:0]   o_pattern_index,
    output logic [bbwc_pkg::NUM_BARS-1:0]   o_wide_bar_mask,
    output logic [bbwc_pkg::NUM_GAPS-1:0]   o_wide_gap_mask
);
    import bbwc_pkg::*;

    // Compare width covers both the sample and the register
    localparam int CMP_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
    localparam logic [CMP_BITS-1:0] S_MASK = {CMP_BITS{1'b1}} >> (CMP_BITS - SAMPLE_BITS);
    localparam logic [CMP_BITS-1:0] THR_RST = CMP_BITS'(DARK_THR_RST) & S_MASK;

    logic [CMP_BITS-1:0]  r_thr;
    logic                 r_in_dark, n_in_dark;
    logic [SLOT_BITS-1:0] r_bars_seen, n_bars_seen;
    logic [TIME_BITS-1:0] r_bar_start [NUM_BARS];
    // End of the last bar is never stored: it is the current timestamp at decode
    logic [TIME_BITS-1:0] r_bar_end [NUM_GAPS];

    logic                 r_w_vld;
    logic [NUM_BARS-1:0][TIME_BITS-1:0] r_bar_w, n_bar_w;
    logic [NUM_GAPS-1:0][TIME_BITS-1:0] r_gap_w, n_gap_w;

    logic                 r_out_vld;
    t_result              r_res;
    t_result              cls_res;

    logic                 in_xfer, out_adv, w_adv;
    logic [CMP_BITS-1:0]  s_ext;
    logic                 rise, fall, fire;

    // Handshake
    assign out_adv    = !r_out_vld || !i_out_stall;
    assign w_adv      = !r_w_vld || out_adv;
    assign o_in_stall = !w_adv;
    assign in_xfer    = i_in_valid && w_adv;

    // Threshold crossings; a sample equal to the threshold does nothing
    assign s_ext = CMP_BITS'(i_sample);
    assign rise  = in_xfer && (s_ext > r_thr) && !r_in_dark;
    assign fall  = in_xfer && (s_ext < r_thr) && r_in_dark;
    assign fire  = fall && (r_bars_seen == LAST_SLOT);

    always_comb begin
        n_in_dark   = r_in_dark;
        n_bars_seen = r_bars_seen;
        priority if (rise) begin
            n_in_dark = 1'b1;
        end else if (fire) begin
            n_in_dark   = 1'b0;
            n_bars_seen = '0;
        end else if (fall) begin
            n_in_dark   = 1'b0;
            n_bars_seen = r_bars_seen + 1'b1;
        end
    end

    // Widths of the symbol closed by this sample
    always_comb begin
        for (int i = 0; i < NUM_GAPS; i++) begin
            n_bar_w[i] = r_bar_end[i] - r_bar_start[i];
            n_gap_w[i] = r_bar_start[i+1] - r_bar_end[i];
        end
        n_bar_w[NUM_BARS-1] = i_elapsed_time - r_bar_start[NUM_BARS-1];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RST;
            r_in_dark   <= 1'b0;
            r_bars_seen <= '0;
            r_w_vld     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= CMP_BITS'(i_cfg_wr_data) & S_MASK;
            end
            r_in_dark   <= n_in_dark;
            r_bars_seen <= n_bars_seen;
            if (w_adv) begin
                r_w_vld <= fire;
            end
            if (out_adv) begin
                r_out_vld <= r_w_vld;
            end
        end
    end

    // Bar timing store and stage payloads
    always_ff @(posedge i_clk) begin
        if (rise) begin
            r_bar_start[r_bars_seen] <= i_elapsed_time;
        end
        if (fall && !fire) begin
            r_bar_end[r_bars_seen[GAP_IDX_BITS-1:0]] <= i_elapsed_time;
        end
        if (w_adv && fire) begin
            r_bar_w <= n_bar_w;
            r_gap_w <= n_gap_w;
        end
        if (out_adv && r_w_vld) begin
            r_res <= cls_res;
        end
    end

    bbwc_classify #(
        .TIME_BITS (TIME_BITS)
    ) u_classify (
        .i_bar_w (r_bar_w),
        .i_gap_w (r_gap_w),
        .o_res   (cls_res)
    );

    assign o_out_valid     = r_out_vld;
    assign o_pattern_index = r_res.pattern_index;
    assign o_wide_bar_mask = r_res.wide_bar_mask;
    assign o_wide_gap_mask = r_res.wide_gap_mask;

endmodule

// ===== rtl/bbwc_classify.sv =====
// Width classifier: marks wide bars and the wide gap, forms the pattern index.
// Depends on bbwc_pkg. Purely combinational, sits between width and result registers.
module bbwc_classify #(
    parameter int TIME_BITS = bbwc_pkg::TIME_BITS_DEF
) (
    input  logic [bbwc_pkg::NUM_BARS-1:0][TIME_BITS-1:0] i_bar_w,
    input  logic [bbwc_pkg::NUM_GAPS-1:0][TIME_BITS-1:0] i_gap_w,
    output bbwc_pkg::t_result                            o_res
);
    import bbwc_pkg::*;

    logic [NUM_BARS-1:0] bar_wide;
    logic [NUM_GAPS-1:0] gap_wide;
    logic [CODE_BITS-1:0] pair_code;
    logic [IDX_BITS-1:0]  gap_ofs;

    // A bar is wide when at most one other bar is strictly wider
    always_comb begin
        logic [SLOT_BITS-1:0] n_wider;
        for (int i = 0; i < NUM_BARS; i++) begin
            n_wider = '0;
            for (int j = 0; j < NUM_BARS; j++) begin
                if (j != i && i_bar_w[j] > i_bar_w[i]) begin
                    n_wider = n_wider + 1'b1;
                end
            end
            bar_wide[i] = (n_wider <= SLOT_BITS'(1));
        end
    end

    // A gap is wide when no other gap is strictly wider
    always_comb begin
        for (int i = 0; i < NUM_GAPS; i++) begin
            gap_wide[i] = 1'b1;
            for (int j = 0; j < NUM_GAPS; j++) begin
                if (j != i && i_gap_w[j] > i_gap_w[i]) begin
                    gap_wide[i] = 1'b0;
                end
            end
        end
    end

    // First matching pair wins: scan from the last so earlier pairs override
    always_comb begin
        pair_code = CODE_NONE;
        for (int k = NUM_PAIRS - 1; k >= 0; k--) begin
            if (bar_wide[PAIR_A[k]] && bar_wide[PAIR_B[k]]) begin
                pair_code = CODE_BITS'(k + 1);
            end
        end
    end

    // Gap offset, gap 1 has priority
    always_comb begin
        priority if (gap_wide[1]) begin
            gap_ofs = GAP1_OFS;
        end else if (gap_wide[2]) begin
            gap_ofs = GAP2_OFS;
        end else if (gap_wide[3]) begin
            gap_ofs = GAP3_OFS;
        end else if (gap_wide[0]) begin
            gap_ofs = GAP0_OFS;
        end else begin
            gap_ofs = GAP_NONE_OFS;
        end
    end

    assign o_res.pattern_index = IDX_BITS'(pair_code) + gap_ofs;
    assign o_res.wide_bar_mask = bar_wide;
    assign o_res.wide_gap_mask = gap_wide;

endmodule

// ===== verif/barcode_bar_width_classifier_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for barcode_bar_width_classifier_top: drives bar/space sample runs,
// predicts each decoded symbol and checks it field by field. Depends on bbwc_pkg and the RTL.

module barcode_bar_width_classifier_top_tb;

    import bbwc_pkg::*;

    localparam int SBITS = SAMPLE_BITS_DEF;
    localparam int TBITS = TIME_BITS_DEF;

    localparam int IDLE_PCT      = 18;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 10;
    localparam int WATCHDOG_MAX  = 2000;

    // Bar pairs in priority order; pair k gives code k+1
    localparam int PAIR_LO [10] = '{0, 1, 0, 2, 0, 1, 3, 0, 1, 2};
    localparam int PAIR_HI [10] = '{4, 4, 1, 4, 2, 2, 4, 3, 3, 3};
    localparam logic [5:0] ADD_GAP1 = 6'd0;
    localparam logic [5:0] ADD_GAP2 = 6'd9;
    localparam logic [5:0] ADD_GAP3 = 6'd19;
    localparam logic [5:0] ADD_GAP0 = 6'd29;

    // Width styles for generated symbols
    localparam int STYLE_CODE39 = 0;
    localparam int STYLE_EXACT  = 1;
    localparam int STYLE_SPREAD = 2;
    localparam int STYLE_HUGE   = 3;

    typedef struct {
        logic [SBITS-1:0] level;
        logic [TBITS-1:0] stamp;
    } t_sample;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]    i_cfg_wr_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [SBITS-1:0]       i_sample = '0;
    logic [TBITS-1:0]       i_elapsed_time = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [IDX_BITS-1:0]    o_pattern_index;
    logic [NUM_BARS-1:0]    o_wide_bar_mask;
    logic [NUM_GAPS-1:0]    o_wide_gap_mask;

    barcode_bar_width_classifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .i_elapsed_time  (i_elapsed_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pattern_index (o_pattern_index),
        .o_wide_bar_mask (o_wide_bar_mask),
        .o_wide_gap_mask (o_wide_gap_mask)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Stimulus and scoreboard state
    t_sample          pending_samples [$];
    t_result          expected_symbols [$];
    t_sample          next_sample;
    t_result          want;
    int               samples_queued = 0;
    int               samples_sent = 0;
    int               mismatches = 0;
    int               idle_cycles = 0;
    int               hold_left = 0;
    logic             hold_kick = 1'b0;
    logic             no_idle = 1'b0;
    logic [TBITS-1:0] scan_time = '0;

    // Predictor copy of the block state
    logic [CFG_BITS-1:0] thr_model = DARK_THR_RST;
    logic                pred_dark = 1'b0;
    logic [2:0]          pred_bars = 3'd0;
    logic [TBITS-1:0]    start_t [NUM_BARS] = '{default: '0};
    logic [TBITS-1:0]    end_t [NUM_BARS] = '{default: '0};

    // Widths, wide marks and pattern index of the five bars now stored
    function automatic t_result classify_symbol();
        logic [TBITS-1:0] bw [NUM_BARS];
        logic [TBITS-1:0] gw [NUM_GAPS];
        logic [TBITS-1:0] top, second, gmax;
        logic [NUM_BARS-1:0] bm;
        logic [NUM_GAPS-1:0] gm;
        logic [5:0] code;
        t_result r;
        top = '0;
        second = '0;
        bm = '0;
        gm = '0;
        code = '0;
        for (int i = 0; i < NUM_BARS; i++) bw[i] = end_t[i] - start_t[i];
        for (int i = 0; i < NUM_GAPS; i++) gw[i] = start_t[i+1] - end_t[i];
        for (int i = 0; i < NUM_BARS; i++) begin
            if (bw[i] > top) begin
                second = top;
                top = bw[i];
            end else if (bw[i] > second) begin
                second = bw[i];
            end
        end
        for (int i = 0; i < NUM_BARS; i++)
            if (bw[i] == top || bw[i] == second) bm[i] = 1'b1;
        gmax = gw[0];
        for (int i = 1; i < NUM_GAPS; i++)
            if (gw[i] > gmax) gmax = gw[i];
        for (int i = 0; i < NUM_GAPS; i++)
            if (gw[i] == gmax) gm[i] = 1'b1;
        // first matching pair wins
        for (int k = 0; k < 10; k++)
            if (code == 0 && bm[PAIR_LO[k]] && bm[PAIR_HI[k]]) code = 6'(k + 1);
        if (gm[1])      code += ADD_GAP1;
        else if (gm[2]) code += ADD_GAP2;
        else if (gm[3]) code += ADD_GAP3;
        else if (gm[0]) code += ADD_GAP0;
        r.pattern_index = code;
        r.wide_bar_mask = bm;
        r.wide_gap_mask = gm;
        return r;
    endfunction

    // Threshold crossing tracker; queues a symbol on the fifth bar end
    task automatic track_sample(input logic [SBITS-1:0] s, input logic [TBITS-1:0] t);
        int slot;
        slot = pred_bars % NUM_BARS;
        if (s > thr_model && !pred_dark) begin
            pred_dark = 1'b1;
            start_t[slot] = t;
        end else if (s < thr_model && pred_dark) begin
            pred_dark = 1'b0;
            end_t[slot] = t;
            pred_bars = 3'(slot + 1);
        end
        if (pred_bars >= NUM_BARS) begin
            expected_symbols.push_back(classify_symbol());
            pred_dark = 1'b0;
            pred_bars = 3'd0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Input driver: offers queued samples, predicts on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                track_sample(i_sample, i_elapsed_time);
                samples_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_sample = pending_samples.pop_front();
                    i_in_valid     <= 1'b1;
                    i_sample       <= next_sample.level;
                    i_elapsed_time <= next_sample.stamp;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each result transfer, drives random stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_symbols.size() == 0) begin
                    report_mismatch($sformatf("unexpected symbol idx=%0d bars=%b gaps=%b",
                        o_pattern_index, o_wide_bar_mask, o_wide_gap_mask));
                end else begin
                    want = expected_symbols.pop_front();
                    if (o_pattern_index !== want.pattern_index)
                        report_mismatch($sformatf("pattern_index got %0d want %0d",
                            o_pattern_index, want.pattern_index));
                    if (o_wide_bar_mask !== want.wide_bar_mask)
                        report_mismatch($sformatf("wide_bar_mask got %b want %b",
                            o_wide_bar_mask, want.wide_bar_mask));
                    if (o_wide_gap_mask !== want.wide_gap_mask)
                        report_mismatch($sformatf("wide_gap_mask got %b want %b",
                            o_wide_gap_mask, want.wide_gap_mask));
                end
            end
            i_out_stall <= (hold_left != 0) || (!no_idle && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Long receiver hold-off, started by a kick from the sequence
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles++;
            end
        end
    end

    function automatic logic [SBITS-1:0] dark_level();
        return SBITS'($urandom_range(int'(thr_model) + 1, (1 << SBITS) - 1));
    endfunction

    function automatic logic [SBITS-1:0] light_level();
        return SBITS'($urandom_range(0, int'(thr_model) - 1));
    endfunction

    function automatic logic [TBITS-1:0] element_width(input int style, input bit wide);
        case (style)
            STYLE_CODE39: return wide ? $urandom_range(14, 20) : $urandom_range(4, 8);
            STYLE_EXACT:  return wide ? 15 : 5;
            STYLE_SPREAD: return $urandom_range(0, 60);
            default:      return $urandom();
        endcase
    endfunction

    task automatic push_sample(input logic [SBITS-1:0] s, input logic [TBITS-1:0] t);
        t_sample item;
        item.level = s;
        item.stamp = t;
        pending_samples.push_back(item);
        samples_queued++;
    endtask

    // One bar or space: the crossing sample, then a few filler samples
    // (some sitting exactly on the threshold) before the next edge
    task automatic emit_run(input bit dark, input logic [TBITS-1:0] dur, input int max_extra);
        int extra;
        extra = $urandom_range(0, max_extra);
        push_sample(dark ? dark_level() : light_level(), scan_time);
        for (int j = 1; j <= extra; j++)
            if (dur > j)
                push_sample(($urandom_range(0, 4) == 0) ? SBITS'(thr_model) :
                            (dark ? dark_level() : light_level()), scan_time + j);
        scan_time += dur;
    endtask

    // Quiet zone then a number of bar/space pairs (five for a full symbol)
    task automatic queue_symbol(input int style, input int bars, input int max_extra);
        int wa, wb, wg;
        bit wide;
        wa = $urandom_range(0, 4);
        wb = (wa + $urandom_range(1, 4)) % NUM_BARS;
        wg = $urandom_range(0, 3);
        if ($urandom_range(0, 5) == 0) scan_time = $urandom();
        emit_run(1'b0, $urandom_range(1, 8), max_extra);
        for (int i = 0; i < bars; i++) begin
            wide = (style == STYLE_EXACT) ? 1'($urandom_range(0, 1)) : (i == wa || i == wb);
            emit_run(1'b1, element_width(style, wide), max_extra);
            wide = (style == STYLE_EXACT) ? 1'($urandom_range(0, 1)) : (i == wg);
            emit_run(1'b0, element_width(style, wide), max_extra);
        end
    endtask

    task automatic push_noise();
        if ($urandom_range(0, 1) == 0) scan_time = $urandom();
        else scan_time += $urandom_range(0, 9);
        push_sample(SBITS'($urandom_range(0, (1 << SBITS) - 1)), scan_time);
    endtask

    // Mostly full symbols, some cut short, some noise
    task automatic run_mixed(input int count);
        int target, r;
        target = samples_queued + count;
        while (samples_queued < target) begin
            r = $urandom_range(0, 99);
            if (r < 10) push_noise();
            else if (r < 22) queue_symbol($urandom_range(0, 3), $urandom_range(1, 4), 2);
            else queue_symbol($urandom_range(0, 3), NUM_BARS, 2);
        end
    endtask

    task automatic wait_for_drain();
        while (samples_sent != samples_queued || expected_symbols.size() != 0)
            @(posedge i_clk);
    endtask

    // Only called with the block idle; the tracker may still be mid-symbol
    task automatic write_threshold(input logic [CFG_BITS-1:0] value);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        thr_model = value;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all five bars and gaps of zero width at the top timestamp,
        // extreme levels, and one sample sitting on the threshold
        for (int i = 0; i < NUM_BARS; i++) begin
            push_sample('1, '1);
            if (i == 2) push_sample(SBITS'(thr_model), '1);
            push_sample('0, '1);
        end
        // Directed: Code 39 shaped widths with one bar whose end runs backwards
        scan_time = '0;
        emit_run(1'b1, 10, 0);
        emit_run(1'b0, 5, 0);
        emit_run(1'b1, 10, 0);
        emit_run(1'b0, 5, 0);
        emit_run(1'b1, 32'hFFFF_FFF0, 0);
        emit_run(1'b0, 30, 0);
        emit_run(1'b1, 4, 0);
        emit_run(1'b0, 5, 0);
        emit_run(1'b1, 4, 0);
        emit_run(1'b0, 1, 0);
        wait_for_drain();

        // Random at the reset threshold, with a full sender pause halfway
        run_mixed(70);
        wait_for_drain();
        run_mixed(70);

        // Threshold extremes: at zero no sample reads light, at all ones no sample reads dark
        write_threshold('0);
        for (int i = 0; i < 25; i++) push_noise();
        write_threshold('1);
        for (int i = 0; i < 25; i++) push_noise();

        write_threshold(CFG_BITS'($urandom_range(200, 3900)));
        run_mixed(100);

        // Back-pressure: receiver holds off while the sender keeps going
        @(posedge i_clk);
        no_idle <= 1'b1;
        for (int i = 0; i < 10; i++) queue_symbol(STYLE_CODE39, NUM_BARS, 1);
        hold_kick <= 1'b1;
        @(posedge i_clk);
        hold_kick <= 1'b0;
        wait_for_drain();
        no_idle <= 1'b0;

        write_threshold(CFG_BITS'(1));
        run_mixed(90);
        write_threshold(CFG_BITS'((1 << CFG_BITS) - 2));
        run_mixed(90);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== barcode_bar_width_classifier_top.f =====
rtl/bbwc_pkg.sv
rtl/bbwc_classify.sv
rtl/barcode_bar_width_classifier_top.sv
verif/barcode_bar_width_classifier_top_tb.sv
